// ===== rtl/fifo_ready_queue_with_removal_top_assert.svh =====
// Assertion macros for the ready queue. Each macro expects clk and rst_n in scope.
`ifndef FIFO_READY_QUEUE_WITH_REMOVAL_TOP_ASSERT_SVH
`define FIFO_READY_QUEUE_WITH_REMOVAL_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/frq_pkg.sv =====
`timescale 1ns / 1ps
package frq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Fixed field widths on the ports.
  localparam int CMD_BITS    = 2;
  localparam int TID_BITS    = 8;
  localparam int STAT_BITS   = 2;
  localparam int COUNT_BITS  = 5;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [CMD_BITS-1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_REM = 2'd2
  } op_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    enqueue;
    logic    take_head;
    logic    clear_scan;
    logic    step_scan;
    logic    shift;
    logic    set_st;
    status_t st_code;
    logic    load_out;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic hit;
    logic scan_last;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== rtl/frq_ctrl.sv =====
`timescale 1ns / 1ps
module frq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  frq_pkg::ctl_sts_t sts,
  output frq_pkg::ctl_cmd_t cmd
);
  import frq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_DEQ:  state_nxt = sts.empty ? S_DONE : S_SHIFT;
          OP_REM:  state_nxt = sts.empty ? S_DONE : S_SEARCH;
          default: state_nxt = S_DONE;
        endcase
      end
      S_SEARCH: begin
        if (sts.hit) begin
          state_nxt = S_SHIFT;
        end else if (sts.scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.st_code = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.capture  = in_tvalid;
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_ENQ: begin
            if (sts.full) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_FULL;
            end else begin
              cmd.enqueue = 1'b1;
            end
          end
          OP_DEQ: begin
            if (sts.empty) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_EMPTY;
            end else begin
              cmd.take_head  = 1'b1;
              cmd.clear_scan = 1'b1;
            end
          end
          OP_REM: begin
            if (sts.empty) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_NOT_FOUND;
            end else begin
              cmd.clear_scan = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_SEARCH: begin
        if (!sts.hit) begin
          if (sts.scan_last) begin
            cmd.set_st  = 1'b1;
            cmd.st_code = ST_NOT_FOUND;
          end else begin
            cmd.step_scan = 1'b1;
          end
        end
      end
      S_SHIFT: cmd.shift = 1'b1;
      S_DONE:  cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/frq_dp.sv =====
`timescale 1ns / 1ps
module frq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [frq_pkg::CMD_BITS-1:0]        in_cmd,
  input  logic [frq_pkg::TID_BITS-1:0]        in_tid,
  input  logic                                out_tready,
  input  frq_pkg::ctl_cmd_t                   cmd,
  output frq_pkg::ctl_sts_t                   sts,
  output logic                                out_tvalid,
  output logic [frq_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [frq_pkg::STAT_BITS-1:0]       out_tuser
);
  import frq_pkg::*;

  logic [ID_BITS-1:0]    ent_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]      occ_r;
  logic [CNT_W-1:0]      occ_nxt;
  logic [IDX_W-1:0]      scan_r;
  logic [CMD_BITS-1:0]   op_r;
  logic [ID_BITS-1:0]    id_r;
  logic [ID_BITS-1:0]    chosen_r;
  status_t               st_r;
  logic                  out_valid_r;
  logic [TID_BITS-1:0]   out_id_r;
  logic [STAT_BITS-1:0]  out_st_r;
  logic [COUNT_BITS-1:0] out_cnt_r;

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.enqueue) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (cmd.shift) begin
      occ_nxt = occ_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Entry storage: the head is entry zero, and closing a gap moves every
  // entry above the scan position down by one, over the entry at it.
  always_ff @(posedge clk) begin
    if (cmd.enqueue) begin
      ent_r[occ_r[IDX_W-1:0]] <= id_r;
    end
    if (cmd.shift) begin
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
        if (IDX_W'(k) >= scan_r) ent_r[k] <= ent_r[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_cmd;
      id_r     <= ID_BITS'(in_tid);
      chosen_r <= '0;
      st_r     <= ST_OK;
    end else begin
      if (cmd.take_head) chosen_r <= ent_r[0];
      if (cmd.set_st)    st_r     <= cmd.st_code;
    end
    if (cmd.clear_scan) begin
      scan_r <= '0;
    end else if (cmd.step_scan) begin
      scan_r <= scan_r + IDX_W'(1);
    end
    if (cmd.load_out) begin
      out_id_r  <= TID_BITS'(chosen_r);
      out_st_r  <= st_r;
      out_cnt_r <= COUNT_BITS'(occ_r);
    end
  end

  always_comb begin
    sts.op        = op_t'(op_r);
    sts.full      = (occ_r == CNT_W'(QUEUE_DEPTH));
    sts.empty     = (occ_r == '0);
    sts.hit       = (ent_r[scan_r] == id_r);
    sts.scan_last = ({1'b0, scan_r} == (occ_r - CNT_W'(1)));
    sts.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - TID_BITS - COUNT_BITS)'(0), out_cnt_r, out_id_r};
  assign out_tuser  = out_st_r;

endmodule

// ===== rtl/fifo_ready_queue_with_removal_top.sv =====
// Sequence: after the input transfer, enqueue passes DECODE and DONE; dequeue DECODE, SHIFT
//   and DONE; remove DECODE, SEARCH (one entry per cycle), SHIFT on a hit and DONE.
// An empty queue skips SHIFT and SEARCH. Throughput: one item at a time; the next is taken
//   once the result has left DONE, and a remove that searches the whole list takes longest.
// Reset: synchronous active-low rst_n empties the queue and drops any pending result;
//   entry contents are not cleared.
`timescale 1ns / 1ps
`include "fifo_ready_queue_with_removal_top_assert.svh"
module fifo_ready_queue_with_removal_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [frq_pkg::IN_TDATA_W-1:0]      in_tdata,   // [7:0] thread_id
  input  logic [frq_pkg::CMD_BITS-1:0]        in_tuser,   // [1:0] command
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [frq_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [7:0] chosen_id, [12:8] entry_count
  output logic [frq_pkg::STAT_BITS-1:0]       out_tuser   // [1:0] status
);
  import frq_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  frq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  frq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_cmd     (in_tuser),
    .in_tid     (in_tdata[TID_BITS-1:0]),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  assign in_tready = cmd.in_ready;

  `FRQ_ASSERT_NEXT(a_one_item_at_a_time, in_tvalid && in_tready, !in_tready, "input taken while busy")
  `FRQ_ASSERT_SAME(a_count_bound, out_tvalid, out_tdata[12:8] <= COUNT_BITS'(QUEUE_DEPTH), "count above depth")
  `FRQ_ASSERT_SAME(a_full_count, out_tvalid && (out_tuser == ST_FULL), out_tdata[12:8] == COUNT_BITS'(QUEUE_DEPTH), "full status with room left")
  `FRQ_ASSERT_SAME(a_empty_result, out_tvalid && (out_tuser == ST_EMPTY), (out_tdata[12:8] == '0) && (out_tdata[7:0] == '0), "empty status with entries or an id")

endmodule
